>>> design/cell_charge_monitor_unit_defines.svh
// Assertion macros used by the charge monitor top module.
// The macros expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef CELL_CHARGE_MONITOR_UNIT_DEFINES_SVH
`define CELL_CHARGE_MONITOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CCM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ccm assertion failed");
`define CCM_ASSERT_IMPLY(lbl, pre, post) \
	`CCM_ASSERT(lbl, (pre) |-> (post))
`else
`define CCM_ASSERT(lbl, prop)
`define CCM_ASSERT_IMPLY(lbl, pre, post)
`endif
`endif

>>> design/ccm_pkg.sv
`timescale 1ns / 1ps
package ccm_pkg;
	localparam int SAMPLES   = 16;
	localparam int NUM_CELLS = 4;
	localparam int LEVEL_W   = 10;
	localparam int AVG_SHIFT = 4;
	localparam int SUM_W     = LEVEL_W + $clog2(SAMPLES);
	localparam int CNT_W     = $clog2(SAMPLES + 1);
	localparam int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam int MASK_W    = NUM_CELLS;
	localparam int REG_IDX_W = 3;
	localparam int BAR_W     = 3;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

	localparam logic [REG_IDX_W-1:0] REG_OPEN = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BAD  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FULL = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_HOLD = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BAR2 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BAR3 = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_BAR4 = 3'd6;

	localparam logic [LEVEL_W-1:0] RST_OPEN = 10'h3FB;
	localparam logic [LEVEL_W-1:0] RST_BAD  = 10'h1A6;
	localparam logic [LEVEL_W-1:0] RST_FULL = 10'h344;
	localparam logic [LEVEL_W-1:0] RST_HOLD = 10'h311;
	localparam logic [LEVEL_W-1:0] RST_BAR2 = 10'h201;
	localparam logic [LEVEL_W-1:0] RST_BAR3 = 10'h25B;
	localparam logic [LEVEL_W-1:0] RST_BAR4 = 10'h2B6;

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic KIND_PULSE  = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	localparam logic [1:0] ST_OPEN     = 2'd0;
	localparam logic [1:0] ST_BAD      = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_CHARGING = 2'd3;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [MASK_W-1:0] mask_t;

	typedef struct packed {
		level_t open_level;
		level_t bad_level;
		level_t full_level;
		level_t hold_level;
		level_t bar2_level;
		level_t bar3_level;
		level_t bar4_level;
	} cfg_t;

	typedef struct packed {
		logic              done;
		level_t            avg;
		logic [CELL_W-1:0] cell_idx;
	} acc_t;

	typedef struct packed {
		logic             kind;
		mask_t            pulse_mask;
		logic [1:0]       cell_res;
		level_t           average;
		logic [1:0]       status;
		logic [BAR_W-1:0] bar_level;
		mask_t            charging_mask;
		mask_t            full_mask;
	} result_t;

	function automatic mask_t even_cells();
		mask_t m;
		for (int i = 0; i < MASK_W; i++) begin
			m[i] = ((i % 2) == 0);
		end
		return m;
	endfunction
endpackage

>>> design/cell_charge_monitor_unit.sv
`timescale 1ns / 1ps
// Charge monitor for four cells measured in turn.
// The input channel (in_valid, in_stall) carries either a timer tick or one converter
// sample of the cell under measurement. A tick yields a pulse result at once; every
// sixteenth sample completes a set and yields a cell report, other samples yield nothing.
// The output channel (out_valid, out_stall) carries one result per transfer.
// Each transfer is captured in an input register, worked on from there and written to
// the output register, which offers the result to the receiver.
// One item is taken every cycle while the output is not stalled.
// When the receiver stalls, the pending result holds in the output register. Samples that
// complete no set keep flowing; once an item that yields a result waits in the input
// register, stall rises at the input.
// The user must write the threshold registers (wr_en, wr_index, wr_data) only while the
// block is idle; the block does not enforce this. An asynchronous reset clears sums,
// counts, masks and pulse phase, selects the first cell and loads default thresholds.
`include "cell_charge_monitor_unit_defines.svh"
module cell_charge_monitor_unit import ccm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [LEVEL_W-1:0]   wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 opcode,
	input  logic [9:0]           sample,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 kind,
	output logic [3:0]           pulse_mask,
	output logic [1:0]           cell_res,
	output logic [9:0]           average,
	output logic [1:0]           status,
	output logic [2:0]           bar_level,
	output logic [3:0]           charging_mask,
	output logic [3:0]           full_mask
);
	cfg_t    cfg_q;
	logic    valid_s1;
	logic    opcode_s1;
	level_t  sample_s1;
	logic    out_valid_q;
	result_t out_q;
	acc_t    acc;
	result_t res;
	logic    produces;
	logic    can_load;
	logic    adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_level <= RST_OPEN;
			cfg_q.bad_level  <= RST_BAD;
			cfg_q.full_level <= RST_FULL;
			cfg_q.hold_level <= RST_HOLD;
			cfg_q.bar2_level <= RST_BAR2;
			cfg_q.bar3_level <= RST_BAR3;
			cfg_q.bar4_level <= RST_BAR4;
		end else if (wr_en) begin
			case (wr_index)
				REG_OPEN: cfg_q.open_level <= wr_data;
				REG_BAD:  cfg_q.bad_level  <= wr_data;
				REG_FULL: cfg_q.full_level <= wr_data;
				REG_HOLD: cfg_q.hold_level <= wr_data;
				REG_BAR2: cfg_q.bar2_level <= wr_data;
				REG_BAR3: cfg_q.bar3_level <= wr_data;
				REG_BAR4: cfg_q.bar4_level <= wr_data;
				default: ;
			endcase
		end
	end

	assign produces = (opcode_s1 == OP_TICK) || acc.done;
	assign can_load = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && (!produces || can_load);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			opcode_s1 <= opcode;
			sample_s1 <= sample;
		end
	end

	ccm_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv && (opcode_s1 == OP_SAMPLE)),
		.sample (sample_s1),
		.acc    (acc)
	);

	ccm_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.is_tick   (opcode_s1 == OP_TICK),
		.tick_en   (adv && (opcode_s1 == OP_TICK)),
		.report_en (adv && (opcode_s1 == OP_SAMPLE) && acc.done),
		.acc       (acc),
		.cfg       (cfg_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= adv && produces;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && adv && produces) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_q.kind;
	assign pulse_mask    = out_q.pulse_mask;
	assign cell_res      = out_q.cell_res;
	assign average       = out_q.average;
	assign status        = out_q.status;
	assign bar_level     = out_q.bar_level;
	assign charging_mask = out_q.charging_mask;
	assign full_mask     = out_q.full_mask;

	`CCM_ASSERT_IMPLY(a_masks_disjoint, out_valid, (charging_mask & full_mask) == 4'd0)
	`CCM_ASSERT_IMPLY(a_bar_iff_charging, out_valid && (kind == KIND_REPORT), (status == ST_CHARGING) == (bar_level != 3'd0))
	`CCM_ASSERT_IMPLY(a_pulse_in_charging, out_valid && (kind == KIND_PULSE), (pulse_mask & ~charging_mask) == 4'd0)
	`CCM_ASSERT_IMPLY(a_stall_cause, in_stall, out_valid && out_stall)
endmodule

>>> design/ccm_accum.sv
`timescale 1ns / 1ps
module ccm_accum import ccm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  level_t             sample,
	output acc_t               acc
);
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count_q;
	logic [CELL_W-1:0] cell_q;
	logic [SUM_W-1:0]  sum_next;
	logic [SUM_W-1:0]  shifted;
	logic              done;

	assign sum_next = sum_q + SUM_W'(sample);
	assign shifted  = sum_next >> AVG_SHIFT;
	assign done     = (count_q == CNT_W'(SAMPLES - 1));

	always_comb begin
		acc.done     = done;
		acc.cell_idx = cell_q;
		if (shifted > SUM_W'(LEVEL_MAX)) begin
			acc.avg = LEVEL_MAX;
		end else begin
			acc.avg = shifted[LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			cell_q  <= '0;
		end else if (step) begin
			if (done) begin
				sum_q   <= '0;
				count_q <= '0;
				if (cell_q == CELL_W'(NUM_CELLS - 1)) begin
					cell_q <= '0;
				end else begin
					cell_q <= cell_q + CELL_W'(1);
				end
			end else begin
				sum_q   <= sum_next;
				count_q <= count_q + CNT_W'(1);
			end
		end
	end
endmodule

>>> design/ccm_classify.sv
`timescale 1ns / 1ps
module ccm_classify import ccm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    is_tick,
	input  logic    tick_en,
	input  logic    report_en,
	input  acc_t    acc,
	input  cfg_t    cfg,
	output result_t res
);
	mask_t            charge_q;
	mask_t            full_q;
	logic             phase_q;
	mask_t            cell_bit;
	mask_t            charge_new;
	mask_t            full_new;
	mask_t            pulse;
	logic [1:0]       status_c;
	logic [BAR_W-1:0] bar_c;

	always_comb begin
		cell_bit   = MASK_W'(1) << acc.cell_idx;
		charge_new = charge_q & ~cell_bit;
		full_new   = full_q & ~cell_bit;
		status_c   = ST_OPEN;
		bar_c      = '0;
		if (acc.avg >= cfg.open_level) begin
			status_c = ST_OPEN;
		end else if (acc.avg < cfg.bad_level) begin
			status_c = ST_BAD;
		end else if ((acc.avg >= cfg.full_level) ||
				((acc.avg > cfg.hold_level) && ((full_q & cell_bit) != '0))) begin
			full_new = full_q | cell_bit;
			status_c = ST_FULL;
		end else begin
			charge_new = charge_new | cell_bit;
			status_c   = ST_CHARGING;
			bar_c      = BAR_W'(1) + BAR_W'(acc.avg >= cfg.bar2_level)
				+ BAR_W'(acc.avg >= cfg.bar3_level) + BAR_W'(acc.avg >= cfg.bar4_level)
				+ BAR_W'(acc.avg >= cfg.hold_level);
		end
	end

	assign pulse = charge_q & (phase_q ? even_cells() : ~even_cells());

	always_comb begin
		if (is_tick) begin
			res.kind          = KIND_PULSE;
			res.pulse_mask    = pulse;
			res.cell_res      = '0;
			res.average       = '0;
			res.status        = ST_OPEN;
			res.bar_level     = '0;
			res.charging_mask = charge_q;
			res.full_mask     = full_q;
		end else begin
			res.kind          = KIND_REPORT;
			res.pulse_mask    = '0;
			res.cell_res      = 2'(acc.cell_idx);
			res.average       = acc.avg;
			res.status        = status_c;
			res.bar_level     = bar_c;
			res.charging_mask = charge_new;
			res.full_mask     = full_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_q <= '0;
			full_q   <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (tick_en) begin
				phase_q <= ~phase_q;
			end
			if (report_en) begin
				charge_q <= charge_new;
				full_q   <= full_new;
			end
		end
	end
endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import ccm_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_OFF    = 400;
	localparam int SETTLE      = 6;

	typedef struct packed {
		bit      on;
		result_t res;
	} pinned_t;

	typedef struct packed {
		logic       op;
		level_t     smp;
		logic [5:0] reps;
		bit         pinned;
		result_t    res;
	} step_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [LEVEL_W-1:0]   wr_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 opcode = OP_TICK;
	logic [9:0]           sample = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 kind;
	logic [3:0]           pulse_mask;
	logic [1:0]           cell_res;
	logic [9:0]           average;
	logic [1:0]           status;
	logic [2:0]           bar_level;
	logic [3:0]           charging_mask;
	logic [3:0]           full_mask;

	// Model state of the monitor.
	cfg_t  lv = '{RST_OPEN, RST_BAD, RST_FULL, RST_HOLD, RST_BAR2, RST_BAR3, RST_BAR4};
	int    sum_acc = 0;
	int    sample_cnt = 0;
	int    meas_cell = 0;
	mask_t charge_m = '0;
	mask_t full_m = '0;
	logic  tick_phase = 1'b0;

	result_t pending_results[$];
	pinned_t typed_results[$];

	int err_cnt = 0;
	int quiet = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int hold_left = 0;
	int set_pos = 0;
	int set_centre = 0;
	bit set_noisy = 1'b0;

	// Rows of repeated transfers; the typed result belongs to the last transfer of a row.
	step_row_t directed_steps [14] = '{
		'{OP_TICK, 10'd0, 6'd1, 1'b1,
			'{KIND_PULSE, 4'd0, 2'd0, 10'd0, ST_OPEN, 3'd0, 4'd0, 4'd0}},
		'{OP_SAMPLE, 10'd1023, 6'd16, 1'b1,
			'{KIND_REPORT, 4'd0, 2'd0, 10'd1023, ST_OPEN, 3'd0, 4'd0, 4'd0}},
		'{OP_SAMPLE, 10'd0, 6'd16, 1'b1,
			'{KIND_REPORT, 4'd0, 2'd1, 10'd0, ST_BAD, 3'd0, 4'd0, 4'd0}},
		'{OP_SAMPLE, 10'd600, 6'd8, 1'b0, '0},
		'{OP_TICK, 10'd1023, 6'd1, 1'b0, '0},
		'{OP_SAMPLE, 10'd600, 6'd8, 1'b0, '0},
		'{OP_TICK, 10'd0, 6'd2, 1'b0, '0},
		'{OP_SAMPLE, 10'd1000, 6'd16, 1'b0, '0},
		'{OP_SAMPLE, 10'd800, 6'd16, 1'b0, '0},
		'{OP_SAMPLE, 10'd450, 6'd16, 1'b0, '0},
		'{OP_SAMPLE, 10'd850, 6'd16, 1'b0, '0},
		'{OP_SAMPLE, 10'd790, 6'd16, 1'b0, '0},
		'{OP_TICK, 10'd0, 6'd2, 1'b0, '0},
		'{OP_SAMPLE, 10'd420, 6'd16, 1'b0, '0}
	};

	cell_charge_monitor_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.pulse_mask    (pulse_mask),
		.cell_res      (cell_res),
		.average       (average),
		.status        (status),
		.bar_level     (bar_level),
		.charging_mask (charging_mask),
		.full_mask     (full_mask)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic predict_item(input logic op, input level_t smp, output bit made,
			output result_t r);
		mask_t cell_bit;
		int    avg;
		r = '0;
		made = 1'b1;
		if (op == OP_TICK) begin
			r.kind = KIND_PULSE;
			for (int i = 0; i < NUM_CELLS; i++) begin
				if (charge_m[i] && (tick_phase == ((i % 2) == 0))) begin
					r.pulse_mask[i] = 1'b1;
				end
			end
			tick_phase = ~tick_phase;
		end else begin
			sum_acc += smp;
			sample_cnt++;
			if (sample_cnt < SAMPLES) begin
				made = 1'b0;
				return;
			end
			avg = sum_acc >> AVG_SHIFT;
			if (avg > LEVEL_MAX) begin
				avg = LEVEL_MAX;
			end
			cell_bit = mask_t'(1) << meas_cell;
			charge_m &= ~cell_bit;
			r.kind = KIND_REPORT;
			r.cell_res = 2'(meas_cell);
			r.average = level_t'(avg);
			if (avg >= lv.open_level) begin
				full_m &= ~cell_bit;
				r.status = ST_OPEN;
			end else if (avg < lv.bad_level) begin
				full_m &= ~cell_bit;
				r.status = ST_BAD;
			end else if (avg >= lv.full_level ||
					(avg > lv.hold_level && (full_m & cell_bit) != '0)) begin
				full_m |= cell_bit;
				r.status = ST_FULL;
			end else begin
				charge_m |= cell_bit;
				full_m &= ~cell_bit;
				r.status = ST_CHARGING;
				r.bar_level = 3'(1 + int'(avg >= lv.bar2_level) + int'(avg >= lv.bar3_level)
					+ int'(avg >= lv.bar4_level) + int'(avg >= lv.hold_level));
			end
			sum_acc = 0;
			sample_cnt = 0;
			meas_cell = (meas_cell + 1) % NUM_CELLS;
		end
		r.charging_mask = charge_m;
		r.full_mask = full_m;
	endtask

	task automatic check_field(input string name, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin : accept_mon
		pinned_t pin;
		result_t r;
		bit      made;
		if (arst_n && in_valid && !in_stall) begin
			pin = typed_results.pop_front();
			predict_item(opcode, sample, made, r);
			if (made) begin
				pending_results.push_back(pin.on ? pin.res : r);
			end
		end
	end

	always @(posedge clk) begin : result_mon
		result_t got;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {kind, pulse_mask, cell_res, average, status, bar_level, charging_mask,
				full_mask};
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: kind %0d", kind);
				err_cnt++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", want.kind, got.kind);
				check_field("pulse_mask", want.pulse_mask, got.pulse_mask);
				check_field("cell_res", want.cell_res, got.cell_res);
				check_field("average", want.average, got.average);
				check_field("status", want.status, got.status);
				check_field("bar_level", want.bar_level, got.bar_level);
				check_field("charging_mask", want.charging_mask, got.charging_mask);
				check_field("full_mask", want.full_mask, got.full_mask);
			end
		end
	end

	always @(posedge clk) begin : receiver
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall);
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("tb_top failed");
					$finish;
				end
			end
		end
	end

	task automatic send_item(input logic op, input level_t smp, input pinned_t pin);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		typed_results.push_back(pin);
		in_valid <= 1'b1;
		opcode <= op;
		sample <= smp;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_level(input logic [REG_IDX_W-1:0] idx, input level_t val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			REG_OPEN: lv.open_level = val;
			REG_BAD:  lv.bad_level = val;
			REG_FULL: lv.full_level = val;
			REG_HOLD: lv.hold_level = val;
			REG_BAR2: lv.bar2_level = val;
			REG_BAR3: lv.bar3_level = val;
			default:  lv.bar4_level = val;
		endcase
	endtask

	task automatic load_levels(input cfg_t c);
		write_level(REG_OPEN, c.open_level);
		write_level(REG_BAD, c.bad_level);
		write_level(REG_FULL, c.full_level);
		write_level(REG_HOLD, c.hold_level);
		write_level(REG_BAR2, c.bar2_level);
		write_level(REG_BAR3, c.bar3_level);
		write_level(REG_BAR4, c.bar4_level);
		wr_en <= 1'b0;
	endtask

	function automatic cfg_t ordered_levels();
		cfg_t c;
		int   v;
		v = $urandom_range(0, 140);
		c.bad_level = level_t'(v);
		v += $urandom_range(1, 140);
		c.bar2_level = level_t'(v);
		v += $urandom_range(0, 140);
		c.bar3_level = level_t'(v);
		v += $urandom_range(0, 140);
		c.bar4_level = level_t'(v);
		v += $urandom_range(0, 140);
		c.hold_level = level_t'(v);
		v += $urandom_range(1, 140);
		c.full_level = level_t'(v);
		v += $urandom_range(1, 140);
		c.open_level = level_t'(v);
		return c;
	endfunction

	// Samples mostly come in steady sets centred on a threshold, so that the
	// classification edges and the full hold band are reached often.
	task automatic run_phase(input cfg_t levels, input int idle_pct, input int stall_pct,
			input int items, input bit hold);
		int k;
		int v;
		wait_drained();
		load_levels(levels);
		send_idle = idle_pct;
		recv_stall = stall_pct;
		if (hold) begin
			hold_left = HOLD_OFF;
		end
		for (int n = 0; n < items; n++) begin
			if ($urandom_range(0, 7) == 0) begin
				send_item(OP_TICK, level_t'($urandom), '0);
			end else begin
				if (set_pos == 0) begin
					k = $urandom_range(0, 9);
					set_noisy = (k >= 8);
					if (k < 7) begin
						set_centre = int'(levels[(6 - k) * LEVEL_W +: LEVEL_W]);
					end else begin
						set_centre = int'($urandom_range(0, 1023));
					end
					set_centre = set_centre + int'($urandom_range(0, 6)) - 3;
				end
				if (set_noisy) begin
					v = int'($urandom_range(0, 1023));
				end else begin
					v = set_centre + int'($urandom_range(0, 2)) - 1;
				end
				if (v < 0) begin
					v = 0;
				end else if (v > 1023) begin
					v = 1023;
				end
				send_item(OP_SAMPLE, level_t'(v), '0);
				set_pos = (set_pos + 1) % SAMPLES;
			end
		end
	endtask

	initial begin : stimulus
		pinned_t pin;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed_steps[i]) begin
			for (int k = 0; k < directed_steps[i].reps; k++) begin
				pin = '0;
				if (directed_steps[i].pinned && k == directed_steps[i].reps - 1) begin
					pin = '{1'b1, directed_steps[i].res};
				end
				send_item(directed_steps[i].op, directed_steps[i].smp, pin);
			end
		end
		run_phase('{RST_OPEN, RST_BAD, RST_FULL, RST_HOLD, RST_BAR2, RST_BAR3, RST_BAR4},
			0, 0, 140, 1'b0);
		run_phase('{10'd1023, 10'd0, 10'd1023, 10'd0, 10'd0, 10'd1023, 10'd1023},
			82, 0, 120, 1'b0);
		run_phase(ordered_levels(), 0, 82, 140, 1'b0);
		run_phase('0, 13, 13, 40, 1'b0);
		run_phase('1, 13, 13, 40, 1'b0);
		run_phase(ordered_levels(), 13, 13, 150, 1'b1);
		wait_drained();
		if (err_cnt == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end
endmodule

>>> filelist.f
+incdir+design
design/ccm_pkg.sv
design/ccm_accum.sv
design/ccm_classify.sv
design/cell_charge_monitor_unit.sv
bench/tb_top.sv
